// ----- hdl/ala_pkg.sv -----
`timescale 1ns / 1ps

package ala_pkg;

    // Field widths fixed by the stream format.
    localparam int SAMPLE_W   = 12;
    localparam int THR_W      = 12;
    localparam int GAIN_W     = 2;
    localparam int SUM_W      = 28;
    localparam int FACTOR_W   = 10;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 12;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 32;

    localparam logic [SUM_W-1:0] SUM_MAX = 28'h0FFF_FFFF;

    // Gain indexes of the photo amplifier.
    localparam logic [GAIN_W-1:0] GAIN_X1    = 2'd0;
    localparam logic [GAIN_W-1:0] GAIN_X30   = 2'd1;
    localparam logic [GAIN_W-1:0] GAIN_X1000 = 2'd2;
    localparam logic [GAIN_W-1:0] TOP_GAIN   = GAIN_X1000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_CEILING   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_FLOOR     = 8'd3;

    // Configuration reset values.
    localparam logic [THR_W-1:0]  HIGH_THRESHOLD_RST = 12'd3500;
    localparam logic [THR_W-1:0]  LOW_THRESHOLD_RST  = 12'd100;
    localparam logic [GAIN_W-1:0] GAIN_CEILING_RST   = GAIN_X1000;
    localparam logic [GAIN_W-1:0] GAIN_FLOOR_RST     = GAIN_X1;

    typedef struct packed {
        logic [THR_W-1:0]  high_threshold;
        logic [THR_W-1:0]  low_threshold;
        logic [GAIN_W-1:0] gain_ceiling;
        logic [GAIN_W-1:0] gain_floor;
    } ala_cfg_t;

    typedef struct packed {
        logic              gain_changed;
        logic [GAIN_W-1:0] gain_index;
        logic [SUM_W-1:0]  brightness_sum;
    } ala_result_t;

    // Amplifier gain factor for a gain index; the unused code maps to the top gain.
    function automatic logic [FACTOR_W-1:0] gain_factor(input logic [GAIN_W-1:0] gain);
        logic [FACTOR_W-1:0] factor;
        case (gain)
            GAIN_X1:  factor = 10'd1;
            GAIN_X30: factor = 10'd30;
            default:  factor = 10'd1000;
        endcase
        return factor;
    endfunction

endpackage

// ----- hdl/ala_cfg_regs.sv -----
`timescale 1ns / 1ps

module ala_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ala_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ala_pkg::CFG_DATA_W-1:0]   cfg_data,
    output ala_pkg::ala_cfg_t                cfg
);

    ala_pkg::ala_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Writes to indexes past the last register are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.high_threshold <= ala_pkg::HIGH_THRESHOLD_RST;
            cfg_reg.low_threshold  <= ala_pkg::LOW_THRESHOLD_RST;
            cfg_reg.gain_ceiling   <= ala_pkg::GAIN_CEILING_RST;
            cfg_reg.gain_floor     <= ala_pkg::GAIN_FLOOR_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                ala_pkg::REG_HIGH_THRESHOLD: begin
                    cfg_reg.high_threshold <= cfg_data[ala_pkg::THR_W-1:0];
                end
                ala_pkg::REG_LOW_THRESHOLD: begin
                    cfg_reg.low_threshold <= cfg_data[ala_pkg::THR_W-1:0];
                end
                ala_pkg::REG_GAIN_CEILING: begin
                    cfg_reg.gain_ceiling <= cfg_data[ala_pkg::GAIN_W-1:0];
                end
                ala_pkg::REG_GAIN_FLOOR: begin
                    cfg_reg.gain_floor <= cfg_data[ala_pkg::GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- hdl/ala_step.sv -----
`timescale 1ns / 1ps

module ala_step #(
    parameter int ADC_FULL_SCALE = 4095,
    parameter int AVERAGE_SHIFT  = 6
) (
    input  logic [ala_pkg::SAMPLE_W-1:0] adc_sample,
    input  logic [ala_pkg::SUM_W-1:0]    acc,
    input  logic [ala_pkg::GAIN_W-1:0]   gain,
    input  ala_pkg::ala_cfg_t            cfg,
    output ala_pkg::ala_result_t         result
);

    localparam int INV_W  = $clog2(ADC_FULL_SCALE + 1);
    localparam int CMP_W  = (INV_W > ala_pkg::SAMPLE_W) ? INV_W : ala_pkg::SAMPLE_W;
    localparam int PROD_W = INV_W + ala_pkg::FACTOR_W;
    localparam int ACC_W  = ala_pkg::SUM_W + 1;

    logic [CMP_W-1:0]              sample_ext;
    logic [CMP_W-1:0]              full_ext;
    logic [CMP_W-1:0]              inv_wide;
    logic [INV_W-1:0]              inv;
    logic [ala_pkg::SUM_W-1:0]     leak;
    logic [PROD_W-1:0]             product;
    logic [ACC_W-1:0]              sum;
    logic [ala_pkg::GAIN_W-1:0]    ceil_eff;
    logic                          raise;
    logic                          lower;

    assign sample_ext = CMP_W'(adc_sample);
    assign full_ext   = CMP_W'(ADC_FULL_SCALE);

    // Readings above full scale invert to zero.
    assign inv_wide = (sample_ext > full_ext) ? '0 : (full_ext - sample_ext);
    assign inv      = inv_wide[INV_W-1:0];

    assign leak    = acc - (acc >> AVERAGE_SHIFT);
    assign product = PROD_W'(inv) * PROD_W'(ala_pkg::gain_factor(gain));
    assign sum     = ACC_W'(leak) + ACC_W'(product);

    // A ceiling code above the top gain acts as the top gain.
    assign ceil_eff = (cfg.gain_ceiling > ala_pkg::TOP_GAIN) ? ala_pkg::TOP_GAIN
                                                             : cfg.gain_ceiling;

    assign raise = (inv_wide > CMP_W'(cfg.high_threshold)) && (gain < ceil_eff);
    assign lower = !raise && (inv_wide < CMP_W'(cfg.low_threshold))
                   && (gain > cfg.gain_floor);

    always_comb begin
        result.brightness_sum = (sum > ACC_W'(ala_pkg::SUM_MAX)) ? ala_pkg::SUM_MAX
                                                                 : sum[ala_pkg::SUM_W-1:0];
        if (raise) begin
            result.gain_index = gain + 2'd1;
        end else if (lower) begin
            result.gain_index = gain - 2'd1;
        end else begin
            result.gain_index = gain;
        end
        result.gain_changed = raise || lower;
    end

endmodule

// ----- hdl/autoranging_light_averager_top.sv -----
`timescale 1ns / 1ps

// Autoranging light averager: a 64-point style exponential average of an
// inverted photodiode reading, with automatic stepping of the amplifier gain.
// Input channel s_*: one raw 12-bit converter reading per item. Result channel
// m_*: one item for every input item, holding the saturated 28-bit average
// accumulator, the gain index now in use and a flag that is set when this
// item moved the gain up or down.
// The cfg_* channel writes the thresholds and the gain ceiling and floor. It
// is always ready, and it should be used only while no item is in flight.
// An item accepted into the input register is worked through the step logic and
// its result is loaded into the output register once that register is empty or
// being drained; m_tvalid rises when the result is loaded. One item can be taken
// on every cycle while the receiver keeps m_tready high; the loop that sets
// this rate is the accumulator and gain register, updated once per item.
// When the receiver stalls, the finished result waits in the output register
// and one more item is still taken into the input register; only then does
// s_tready fall. Reset (aresetn low at a clock edge) empties both registers,
// clears the accumulator, sets the lowest gain and restores the register
// reset values.
module autoranging_light_averager_top #(
    parameter int ADC_FULL_SCALE = 4095,
    parameter int AVERAGE_SHIFT  = 6
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Input stream.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [ala_pkg::S_TDATA_W-1:0]        s_tdata,   // [11:0] adc_sample, zero fill
    // Result stream.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [ala_pkg::M_TDATA_W-1:0]        m_tdata,   // [27:0] brightness_sum,
                                                             // [29:28] gain_index,
                                                             // [30] gain_changed, zero fill
    // Configuration writes.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ala_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ala_pkg::CFG_DATA_W-1:0]       cfg_data
);

    ala_pkg::ala_cfg_t              cfg;
    ala_pkg::ala_result_t           step_result;

    logic                           in_valid_reg;
    logic [ala_pkg::SAMPLE_W-1:0]   in_sample_reg;
    logic                           out_valid_reg;
    ala_pkg::ala_result_t           out_result_reg;
    logic [ala_pkg::SUM_W-1:0]      acc_reg;
    logic [ala_pkg::GAIN_W-1:0]     gain_reg;
    logic                           advance;

    ala_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ala_step #(
        .ADC_FULL_SCALE (ADC_FULL_SCALE),
        .AVERAGE_SHIFT  (AVERAGE_SHIFT)
    ) u_step (
        .adc_sample (in_sample_reg),
        .acc        (acc_reg),
        .gain       (gain_reg),
        .cfg        (cfg),
        .result     (step_result)
    );

    // The held item moves on when the output register is empty or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            gain_reg      <= ala_pkg::GAIN_X1;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                acc_reg       <= step_result.brightness_sum;
                gain_reg      <= step_result.gain_index;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_sample_reg <= s_tdata[ala_pkg::SAMPLE_W-1:0];
        end
        if (advance) begin
            out_result_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = ala_pkg::M_TDATA_W'(out_result_reg);

    // The gain register never reaches the unused code, even with a ceiling of three.
    a_gain_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        gain_reg <= ala_pkg::TOP_GAIN)
        else $error("gain index left the valid range");

    // Accumulator and gain move only when an item is worked.
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> ($stable(acc_reg) && $stable(gain_reg)))
        else $error("state changed without an item");

    // A shown result always matches the state it left behind.
    a_result_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_result_reg.brightness_sum == acc_reg
                           && out_result_reg.gain_index == gain_reg))
        else $error("result disagrees with state");

    // The change flag is set exactly when the gain moved on that item.
    a_change_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (out_result_reg.gain_changed == (gain_reg != $past(gain_reg))))
        else $error("gain change flag wrong");

    // A held item that cannot move on stays in the input register.
    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("held item lost");

endmodule
